@@ hdl/daat_pkg.sv @@
// ----------------------------------------------------------------------------
// daat_pkg: shared types and constants of the alarm acknowledgement tracker.
// Holds the item, result and configuration types and the register indexes.
// ----------------------------------------------------------------------------
package daat_pkg;

	// Default receiver capacity of the acknowledgement mask.
	localparam int MAX_RECEIVERS_DEF = 16;

	// Field widths.
	localparam int SEQ_W      = 32;
	localparam int RCV_W      = 4;
	localparam int MASK_W     = 16;
	localparam int DEBOUNCE_W = 16;
	localparam int RETRY_W    = 24;
	localparam int COUNT_W    = 5;

	// Stream and configuration port widths.
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 56;
	localparam int CFG_ADDR_W  = 2;
	localparam int CFG_DATA_W  = 24;

	// Configuration register indexes.
	localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_RETRY    = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_RCV_CNT  = 2'd2;

	// Register values after reset.
	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd40;
	localparam logic [RETRY_W-1:0]    RETRY_RESET    = 24'd5000;
	localparam logic [COUNT_W-1:0]    RCV_CNT_RESET  = 5'd1;

	// Item kinds.
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_ACK  = 1'b1;

	typedef struct packed {
		logic             command;
		logic             pin_level;
		logic             link_up;
		logic [SEQ_W-1:0] ack_alarm_seq;
		logic [RCV_W-1:0] ack_receiver;
	} item_t;

	typedef struct packed {
		logic              send_alarm;
		logic              send_clear;
		logic [SEQ_W-1:0]  alarm_seq;
		logic              alarm_on;
		logic [MASK_W-1:0] ack_mask;
		logic              all_acked;
	} result_t;

	typedef struct packed {
		logic [DEBOUNCE_W-1:0] debounce_ticks;
		logic [RETRY_W-1:0]    retry_ticks;
		logic [COUNT_W-1:0]    receiver_count;
	} cfg_t;

endpackage

@@ hdl/daat_in_stage.sv @@
// ----------------------------------------------------------------------------
// daat_in_stage: input register of the tracker.
// Captures one item and holds it until the engine consumes it.
// ----------------------------------------------------------------------------
module daat_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  daat_pkg::item_t in_item,
	input  logic           adv,
	output logic           valid_s1,
	output daat_pkg::item_t item_s1
);

	logic accept;

	// The register frees up in the same cycle that its item moves on.
	assign in_ready = !valid_s1 || adv;
	assign accept   = in_valid && in_ready;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

endmodule

@@ hdl/daat_engine.sv @@
// ----------------------------------------------------------------------------
// daat_engine: debounce, alarm and acknowledgement state of the tracker.
// Computes the result of the staged item and updates state when it advances.
// ----------------------------------------------------------------------------
module daat_engine #(
	parameter int MAX_RECEIVERS = daat_pkg::MAX_RECEIVERS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  daat_pkg::item_t  item,
	input  daat_pkg::cfg_t   cfg,
	output daat_pkg::result_t res
);

	localparam int AW = (MAX_RECEIVERS > daat_pkg::MASK_W) ? MAX_RECEIVERS : daat_pkg::MASK_W;

	logic                            raw_q, raw_n;
	logic                            stable_q, stable_n;
	logic [daat_pkg::DEBOUNCE_W-1:0] age_q, age_n;
	logic                            alarm_q, alarm_n;
	logic [daat_pkg::SEQ_W-1:0]      seq_q, seq_n;
	logic [MAX_RECEIVERS-1:0]        acked_q, acked_n;
	logic                            sent_q, sent_n;
	logic [daat_pkg::RETRY_W-1:0]    send_age_q, send_age_n;
	logic                            link_q, link_n;
	logic [MAX_RECEIVERS-1:0]        exp_mask;
	logic [AW-1:0]                   acked_ext;
	logic                            all_n;
	logic                            signal;
	logic                            send_c;

	// Receivers whose acknowledgement is expected; counts above capacity saturate.
	always_comb begin
		for (int i = 0; i < MAX_RECEIVERS; i++) begin
			exp_mask[i] = int'(cfg.receiver_count) > i;
		end
	end

	// Next state for the staged item.
	always_comb begin
		raw_n      = raw_q;
		stable_n   = stable_q;
		age_n      = age_q;
		alarm_n    = alarm_q;
		seq_n      = seq_q;
		acked_n    = acked_q;
		sent_n     = sent_q;
		send_age_n = send_age_q;
		link_n     = link_q;
		signal     = 1'b0;
		send_c     = 1'b0;
		if (item.command == daat_pkg::CMD_TICK) begin
			// Both ages advance and saturate.
			if (send_age_q != '1) begin
				send_age_n = send_age_q + 24'd1;
			end
			if (item.pin_level != raw_q) begin
				raw_n = item.pin_level;
				age_n = '0;
			end else if (age_q != '1) begin
				age_n = age_q + 16'd1;
			end
			// A change that persisted long enough becomes the stable level.
			if (item.pin_level != stable_q && age_n >= cfg.debounce_ticks) begin
				stable_n = item.pin_level;
				acked_n  = '0;
				if (item.pin_level) begin
					seq_n   = seq_q + 32'd1;
					alarm_n = 1'b1;
					sent_n  = 1'b0;
					signal  = item.link_up;
				end else begin
					alarm_n = 1'b0;
					send_c  = item.link_up;
				end
			end
			// Resend on link rise, and first send or retry while unacknowledged.
			if (alarm_n && item.link_up) begin
				if (!link_q) begin
					signal = 1'b1;
				end
				if (!(&(acked_n | ~exp_mask)) &&
				    (!sent_n || send_age_n >= cfg.retry_ticks)) begin
					signal = 1'b1;
				end
			end
			if (signal) begin
				sent_n     = 1'b1;
				send_age_n = '0;
			end
			link_n = item.link_up;
		end else if (alarm_q && item.ack_alarm_seq == seq_q) begin
			// Acknowledgement of the current alarm by an expected receiver.
			for (int i = 0; i < MAX_RECEIVERS; i++) begin
				if (i < 16 && item.ack_receiver == 4'(i) && exp_mask[i]) begin
					acked_n[i] = 1'b1;
				end
			end
		end
	end

	assign all_n     = &(acked_n | ~exp_mask);
	assign acked_ext = AW'(acked_n);

	// Result of the staged item.
	always_comb begin
		res.send_alarm = signal;
		res.send_clear = send_c;
		res.alarm_seq  = seq_n;
		res.alarm_on   = alarm_n;
		res.ack_mask   = acked_ext[daat_pkg::MASK_W-1:0];
		res.all_acked  = all_n;
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q      <= 1'b0;
			stable_q   <= 1'b0;
			age_q      <= '0;
			alarm_q    <= 1'b0;
			seq_q      <= '0;
			acked_q    <= '0;
			sent_q     <= 1'b0;
			send_age_q <= '0;
			link_q     <= 1'b0;
		end else if (adv) begin
			raw_q      <= raw_n;
			stable_q   <= stable_n;
			age_q      <= age_n;
			alarm_q    <= alarm_n;
			seq_q      <= seq_n;
			acked_q    <= acked_n;
			sent_q     <= sent_n;
			send_age_q <= send_age_n;
			link_q     <= link_n;
		end
	end

`ifndef SYNTHESIS
	// Alarm and clear are never signaled by the same item.
	a_alarm_clear_excl: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> !(res.send_alarm && res.send_clear))
		else $error("alarm and clear signaled together");

	// An acknowledgement item never signals anything.
	a_ack_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && item.command == daat_pkg::CMD_ACK) |-> (!res.send_alarm && !res.send_clear))
		else $error("acknowledgement item produced a signal");

	// The sequence number only holds or steps by one.
	a_seq_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (seq_q == $past(seq_q) || seq_q == $past(seq_q) + 32'd1))
		else $error("alarm sequence jumped");

	// Acknowledgements exist only while an alarm is open.
	a_acked_needs_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		(acked_q != '0) |-> alarm_q)
		else $error("acknowledgement bits set without an active alarm");

	// A clear always leaves the alarm closed.
	a_clear_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.send_clear) |=> !alarm_q)
		else $error("alarm still active after a clear");
`endif

endmodule

@@ hdl/daat_out_stage.sv @@
// ----------------------------------------------------------------------------
// daat_out_stage: result register of the tracker.
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module daat_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  daat_pkg::result_t res_in,
	output logic              room,
	output logic              valid_s2,
	input  logic              out_ready,
	output daat_pkg::result_t res_s2
);

	// A new result may enter when empty or when the held one leaves now.
	assign room = !valid_s2 || out_ready;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_in;
		end
	end

endmodule

@@ hdl/debounced_alarm_ack_tracker_core.sv @@
// ----------------------------------------------------------------------------
// debounced_alarm_ack_tracker_core: debounced alarm tracker with acknowledgements.
// Each input item is a tick (pin sample and link status) or an acknowledgement;
// each gives exactly one result item with send flags, sequence and ack status.
//
// Input channel s_axis: tuser is the command (0 tick, 1 acknowledgement);
// tdata carries pin level, link status, acknowledged sequence and receiver.
// Output channel m_axis: tdata carries the result fields.
// Configuration: a write with cfg_we high at a clock edge sets the register at
// cfg_addr (0 debounce ticks, 1 retry ticks, 2 receiver count); other indexes
// are ignored. Write only while the block is idle.
// Path: an accepted item waits in the input register; its result is computed
// combinationally and captured in the result register when the item advances.
// Throughput: one item per cycle while the result register has room; the input
// register feeds the engine and the result register whenever that register has room.
// Reset (arst_n low) clears all state and loads the register defaults; no
// clearing pass follows. When m_axis_tready is low the held result stays and
// one more item waits in the input register before s_axis_tready drops.
// ----------------------------------------------------------------------------
module debounced_alarm_ack_tracker_core #(
	parameter int MAX_RECEIVERS = daat_pkg::MAX_RECEIVERS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Fields from bit 0: pin_level, link_up, ack_alarm_seq[31:0], ack_receiver[3:0].
	input  logic [daat_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	// Field: command.
	input  logic                               s_axis_tuser,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// Fields from bit 0: send_alarm, send_clear, alarm_seq[31:0], alarm_on,
	// ack_mask[15:0], all_acked.
	output logic [daat_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	input  logic                               cfg_we,
	input  logic [daat_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [daat_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	daat_pkg::item_t   in_item;
	daat_pkg::item_t   item_s1;
	daat_pkg::result_t res_c;
	daat_pkg::result_t res_s2;
	daat_pkg::cfg_t    cfg_q;
	logic              valid_s1;
	logic              room;
	logic              adv;

	// Unpack the input item.
	always_comb begin
		in_item.command       = s_axis_tuser;
		in_item.pin_level     = s_axis_tdata[0];
		in_item.link_up       = s_axis_tdata[1];
		in_item.ack_alarm_seq = s_axis_tdata[33:2];
		in_item.ack_receiver  = s_axis_tdata[37:34];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= daat_pkg::DEBOUNCE_RESET;
			cfg_q.retry_ticks    <= daat_pkg::RETRY_RESET;
			cfg_q.receiver_count <= daat_pkg::RCV_CNT_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				daat_pkg::CFG_DEBOUNCE: begin
					cfg_q.debounce_ticks <= cfg_wdata[daat_pkg::DEBOUNCE_W-1:0];
				end
				daat_pkg::CFG_RETRY: begin
					cfg_q.retry_ticks <= cfg_wdata[daat_pkg::RETRY_W-1:0];
				end
				daat_pkg::CFG_RCV_CNT: begin
					cfg_q.receiver_count <= cfg_wdata[daat_pkg::COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// The staged item moves on whenever the result register has room.
	assign adv = valid_s1 && room;

	daat_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	daat_engine #(
		.MAX_RECEIVERS (MAX_RECEIVERS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res_c)
	);

	daat_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.res_in    (res_c),
		.room      (room),
		.valid_s2  (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res_s2    (res_s2)
	);

	// Pack the result item.
	always_comb begin
		m_axis_tdata        = '0;
		m_axis_tdata[0]     = res_s2.send_alarm;
		m_axis_tdata[1]     = res_s2.send_clear;
		m_axis_tdata[33:2]  = res_s2.alarm_seq;
		m_axis_tdata[34]    = res_s2.alarm_on;
		m_axis_tdata[50:35] = res_s2.ack_mask;
		m_axis_tdata[51]    = res_s2.all_acked;
	end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the debounced alarm acknowledgement tracker.
// An initial block queues tick and acknowledgement items for several register
// settings. A clocked driver offers them on the input stream, and a local
// tracker model predicts one status item per accepted item. A clocked monitor
// compares every status item field by field. Both sides idle at random, and
// the output side sometimes holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int QUIET_LIMIT = 5000;
	localparam int PRINT_LIMIT = 40;

	// An item waiting to be offered. With live_seq set, the acknowledged sequence
	// is taken from the tracker model when the item is loaded, plus seq_offset.
	typedef struct {
		daat_pkg::item_t it;
		bit              live_seq;
		logic [31:0]     seq_offset;
	} pending_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic [daat_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                             s_axis_tuser = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [daat_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [daat_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
	logic [daat_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

	// Stimulus and expected status items.
	pending_item_t     pending_q[$];
	daat_pkg::result_t expected_status_q[$];
	pending_item_t     next_pending;
	daat_pkg::item_t   offered_item;

	// Register copy used by the tracker model and the stimulus.
	logic [daat_pkg::DEBOUNCE_W-1:0] cfg_debounce = daat_pkg::DEBOUNCE_RESET;
	logic [daat_pkg::RETRY_W-1:0]    cfg_retry = daat_pkg::RETRY_RESET;
	logic [daat_pkg::COUNT_W-1:0]    cfg_receivers = daat_pkg::RCV_CNT_RESET;

	// Tracker model state.
	logic                        pin_raw = 1'b0;
	logic                        pin_stable = 1'b0;
	logic [15:0]                 change_age = '0;
	logic                        alarm_active = 1'b0;
	logic [daat_pkg::SEQ_W-1:0]  seq_no = '0;
	logic [daat_pkg::MASK_W-1:0] acked = '0;
	logic                        sent_once = 1'b0;
	logic [23:0]                 send_age = '0;
	logic                        link_prev = 1'b0;

	// Pin and link levels of the stimulus generator.
	logic gen_pin = 1'b0;
	logic gen_link = 1'b1;

	int send_idle_pct = 17;
	int recv_idle_pct = 84;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;
	int fail_count = 0;

	debounced_alarm_ack_tracker_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata)
	);

	always #10 clk = ~clk;

	// Receivers counted for the acknowledgement mask, saturated at the capacity.
	function automatic int receivers_expected();
		return (cfg_receivers > daat_pkg::MAX_RECEIVERS_DEF) ?
			daat_pkg::MAX_RECEIVERS_DEF : int'(cfg_receivers);
	endfunction

	function automatic logic everyone_acked();
		logic [daat_pkg::MASK_W:0] wanted;
		wanted = (17'd1 << receivers_expected()) - 17'd1;
		return (acked & wanted[daat_pkg::MASK_W-1:0]) == wanted[daat_pkg::MASK_W-1:0];
	endfunction

	// Advance the tracker by one item and return the status it reports.
	function automatic daat_pkg::result_t advance_tracker(daat_pkg::item_t it);
		daat_pkg::result_t r;
		logic              fire;
		r = '0;
		fire = 1'b0;
		if (it.command == daat_pkg::CMD_TICK) begin
			if (send_age != 24'hFF_FFFF) send_age++;
			if (it.pin_level != pin_raw) begin
				pin_raw = it.pin_level;
				change_age = '0;
			end else if (change_age != 16'hFFFF) begin
				change_age++;
			end
			// A raw change that has persisted long enough becomes the stable level.
			if (it.pin_level != pin_stable && change_age >= cfg_debounce) begin
				pin_stable = it.pin_level;
				acked = '0;
				if (it.pin_level) begin
					seq_no = seq_no + 32'd1;
					alarm_active = 1'b1;
					sent_once = 1'b0;
					if (it.link_up) fire = 1'b1;
				end else begin
					alarm_active = 1'b0;
					if (it.link_up) r.send_clear = 1'b1;
				end
			end
			// Signal on link rise, and repeat while acknowledgements are missing.
			if (alarm_active && it.link_up) begin
				if (!link_prev) fire = 1'b1;
				if (!everyone_acked() && (!sent_once || send_age >= cfg_retry)) fire = 1'b1;
			end
			if (fire) begin
				r.send_alarm = 1'b1;
				sent_once = 1'b1;
				send_age = '0;
			end
			link_prev = it.link_up;
		end else if (alarm_active && it.ack_alarm_seq == seq_no
				&& it.ack_receiver < receivers_expected()) begin
			acked[it.ack_receiver] = 1'b1;
		end
		r.alarm_seq = seq_no;
		r.alarm_on = alarm_active;
		r.ack_mask = acked;
		r.all_acked = everyone_acked();
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (fail_count < PRINT_LIMIT)
			$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		fail_count++;
	endtask

	task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
		if (got !== want) report_mismatch(what, got, want);
	endtask

	task automatic queue_tick(logic pin, logic link);
		pending_item_t p;
		p.it = '0;
		p.it.command = daat_pkg::CMD_TICK;
		p.it.pin_level = pin;
		p.it.link_up = link;
		p.live_seq = 1'b0;
		p.seq_offset = '0;
		pending_q.push_back(p);
	endtask

	// With live set, seq is an offset from the sequence current at offer time.
	task automatic queue_ack(bit live, logic [31:0] seq, logic [3:0] rcv);
		pending_item_t p;
		p.it = '0;
		p.it.command = daat_pkg::CMD_ACK;
		p.it.ack_alarm_seq = seq;
		p.it.ack_receiver = rcv;
		p.live_seq = live;
		p.seq_offset = seq;
		pending_q.push_back(p);
	endtask

	task automatic write_register(logic [daat_pkg::CFG_ADDR_W-1:0] idx,
			logic [daat_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		case (idx)
			daat_pkg::CFG_DEBOUNCE: cfg_debounce = val[daat_pkg::DEBOUNCE_W-1:0];
			daat_pkg::CFG_RETRY:    cfg_retry = val[daat_pkg::RETRY_W-1:0];
			daat_pkg::CFG_RCV_CNT:  cfg_receivers = val[daat_pkg::COUNT_W-1:0];
			default:                ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every item is accepted and every status item has come back.
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_q.size() != 0 || s_axis_tvalid || expected_status_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_registers(int debounce, int retry, int receivers);
		wait_idle();
		write_register(daat_pkg::CFG_DEBOUNCE, daat_pkg::CFG_DATA_W'(debounce));
		write_register(daat_pkg::CFG_RETRY, daat_pkg::CFG_DATA_W'(retry));
		write_register(daat_pkg::CFG_RCV_CNT, daat_pkg::CFG_DATA_W'(receivers));
	endtask

	// Queue pin runs of random length with acknowledgements mixed in, plus
	// some fully random items as noise.
	task automatic queue_random_items(int count);
		int made;
		int run_len;
		int eff;
		logic [3:0] rcv;
		logic [31:0] offset;
		pending_item_t p;
		made = 0;
		eff = receivers_expected();
		while (made < count) begin
			if ($urandom_range(9, 0) == 0) begin
				p.it.command = 1'($urandom_range(1, 0));
				p.it.pin_level = 1'($urandom_range(1, 0));
				p.it.link_up = 1'($urandom_range(1, 0));
				p.it.ack_alarm_seq = $urandom();
				p.it.ack_receiver = 4'($urandom_range(15, 0));
				p.live_seq = 1'b0;
				p.seq_offset = '0;
				pending_q.push_back(p);
				made++;
			end else begin
				gen_pin = ~gen_pin;
				if ($urandom_range(3, 0) == 0 || cfg_debounce > 64)
					run_len = $urandom_range(1, 12);
				else
					run_len = int'(cfg_debounce) + $urandom_range(1, 30);
				for (int i = 0; i < run_len && made < count; i++) begin
					if ($urandom_range(14, 0) == 0) gen_link = ~gen_link;
					queue_tick(gen_pin, gen_link);
					made++;
					if ($urandom_range(3, 0) == 0) begin
						if (eff > 0 && $urandom_range(3, 0) != 0)
							rcv = 4'($urandom_range(eff - 1, 0));
						else
							rcv = 4'($urandom_range(15, 0));
						case ($urandom_range(9, 0))
							0:       offset = 32'd1;
							1:       offset = 32'hFFFF_FFFF;
							default: offset = 32'd0;
						endcase
						queue_ack(1'b1, offset, rcv);
						made++;
					end
				end
			end
		end
	endtask

	task automatic random_phase(int debounce, int retry, int receivers,
			int send_pct, int recv_pct, int count, bit long_hold);
		set_registers(debounce, retry, receivers);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		queue_random_items(count);
		if (long_hold) hold_request = 1'b1;
	endtask

	// Input side: offer pending items and predict each accepted one.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				expected_status_q.push_back(advance_tracker(offered_item));
			if (s_axis_tvalid && !s_axis_tready) begin
				// The offered item stays until it is taken.
			end else if (pending_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				next_pending = pending_q.pop_front();
				offered_item = next_pending.it;
				if (next_pending.live_seq)
					offered_item.ack_alarm_seq = seq_no + next_pending.seq_offset;
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= offered_item.command;
				s_axis_tdata <= {2'b00, offered_item.ack_receiver, offered_item.ack_alarm_seq,
					offered_item.link_up, offered_item.pin_level};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Output side: random stalls, with occasional long hold-offs.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = 63;
			m_axis_tready <= 1'b0;
		end else begin
			if ($urandom_range(399, 0) == 0) hold_left = $urandom_range(80, 30);
			m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
		end
	end

	// Compare each accepted status item with the oldest prediction.
	always @(posedge clk) begin
		daat_pkg::result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_status_q.size() == 0) begin
				report_mismatch("unexpected status item", m_axis_tdata[33:2], '0);
			end else begin
				want = expected_status_q.pop_front();
				check_field("send_alarm", m_axis_tdata[0], want.send_alarm);
				check_field("send_clear", m_axis_tdata[1], want.send_clear);
				check_field("alarm_seq", m_axis_tdata[33:2], want.alarm_seq);
				check_field("alarm_on", m_axis_tdata[34], want.alarm_on);
				check_field("ack_mask", m_axis_tdata[50:35], want.ack_mask);
				check_field("all_acked", m_axis_tdata[51], want.all_acked);
				check_field("tdata padding", m_axis_tdata[55:52], '0);
			end
		end
	end

	// Watchdog: too long without any item moving on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t ns: no item moved for %0d cycles", $time, QUIET_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Register values after reset; an acknowledgement with no alarm open.
		queue_ack(1'b0, 32'd0, 4'd0);
		queue_tick(1'b0, 1'b0);
		queue_tick(1'b1, 1'b1);
		queue_tick(1'b0, 1'b1);

		// No debounce, retry on every tick, two receivers.
		set_registers(0, 0, 2);
		queue_tick(1'b0, 1'b0);
		queue_tick(1'b1, 1'b1);
		queue_tick(1'b1, 1'b1);
		queue_ack(1'b1, 32'd0, 4'd0);
		queue_ack(1'b1, 32'd0, 4'd3);
		queue_ack(1'b0, 32'hFFFF_FFFF, 4'd1);
		queue_ack(1'b1, 32'd0, 4'd1);
		queue_tick(1'b1, 1'b1);
		queue_tick(1'b1, 1'b0);
		// Link rise re-signals even with every receiver acknowledged.
		queue_tick(1'b1, 1'b1);
		queue_tick(1'b0, 1'b1);
		queue_ack(1'b1, 32'd0, 4'd0);
		queue_tick(1'b1, 1'b0);
		queue_tick(1'b1, 1'b1);
		queue_tick(1'b0, 1'b0);

		// Receiver count above the capacity saturates to sixteen.
		set_registers(0, 0, 31);
		queue_tick(1'b1, 1'b1);
		queue_ack(1'b1, 32'd0, 4'd15);
		queue_ack(1'b1, 32'd0, 4'd0);
		queue_tick(1'b1, 1'b1);

		// No receivers: everyone counts as acknowledged and nothing is retried.
		set_registers(0, 0, 0);
		queue_tick(1'b1, 1'b1);
		queue_tick(1'b0, 1'b1);
		queue_tick(1'b1, 1'b1);
		queue_tick(1'b1, 1'b1);
		queue_ack(1'b1, 32'd0, 4'd0);
		queue_tick(1'b0, 1'b0);

		wait_idle();
		gen_pin = pin_stable;
		random_phase(3, 5, 4, 17, 84, 300, 1'b0);
		random_phase(8, 1, 16, 84, 17, 300, 1'b0);
		random_phase(1, 12, 3, 0, 0, 300, 1'b1);
		random_phase(65535, 16777215, 17, 0, 0, 40, 1'b1);
		random_phase(0, 2, 1, 0, 0, 100, 1'b0);

		wait_idle();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && expected_status_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
